// ===== design/greedy_window_nms_unit_macros.svh =====
// Assertion helpers shared by the design files.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef GREEDY_WINDOW_NMS_UNIT_MACROS_SVH
`define GREEDY_WINDOW_NMS_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever ante holds, cons holds too
`define GWN_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication: whenever ante holds, cons holds in the following cycle
`define GWN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`else

`define GWN_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define GWN_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== design/gwn_pkg.sv =====
package gwn_pkg;

   // Request kinds carried on req_tuser
   typedef enum logic [1:0] {
      REQ_OFFER = 2'd0,
      REQ_READ  = 2'd1,
      REQ_CLEAR = 2'd2
   } req_kind_type;

   // Result status carried on rsp_tuser
   typedef enum logic [2:0] {
      ST_KEPT       = 3'd0,
      ST_SUPPRESSED = 3'd1,
      ST_COST_REJ   = 3'd2,
      ST_LIST_FULL  = 3'd3,
      ST_READ_OK    = 3'd4,
      ST_BAD_INDEX  = 3'd5,
      ST_CLEARED    = 3'd6
   } status_type;

   // Control register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_COST_THR    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERLAP_THR = 2'd1;

   localparam logic [15:0] COST_THR_RESET    = 16'hFFFF;
   localparam logic [8:0]  OVERLAP_THR_RESET = 9'd128;
   localparam logic [15:0] HIT_MAX           = 16'hFFFF;

   // Window geometry, left edge in the lowest bits
   typedef struct packed {
      logic [11:0]        h;
      logic [11:0]        w;
      logic signed [12:0] y;
      logic signed [12:0] x;
   } box_type;

   // One kept entry in the box memory
   typedef struct packed {
      logic [15:0] cost;
      box_type     box;
   } entry_type;

   // Request payload, win_x in the lowest bits
   typedef struct packed {
      logic [5:0]         read_index;
      logic [15:0]        win_cost;
      logic [11:0]        win_height;
      logic [11:0]        win_width;
      logic signed [12:0] win_y;
      logic signed [12:0] win_x;
   } req_data_type;

   // Result payload, entry_index in the lowest bits, padded to 96 bits
   typedef struct packed {
      logic               pad;
      logic [6:0]         kept_total;
      logic [15:0]        out_cost;
      logic [11:0]        out_height;
      logic [11:0]        out_width;
      logic signed [12:0] out_y;
      logic signed [12:0] out_x;
      logic [15:0]        hit_count;
      logic [5:0]         entry_index;
   } rsp_data_type;

   // Overlap pipeline status toward the sequencer
   typedef struct packed {
      logic busy;
      logic hit;
   } iou_status_type;

endpackage

// ===== design/gwn_iou_pipe.sv =====
`include "greedy_window_nms_unit_macros.svh"

// Four-stage overlap test of one kept window per cycle against the candidate:
// bounds, products, union, threshold product; the match decision is taken
// from the last stage.
module gwn_iou_pipe #(
   parameter int TAG_W = 22
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     flush,
   input  logic                     in_valid,
   input  gwn_pkg::box_type         in_box,
   input  logic [TAG_W-1:0]         in_tag,
   input  gwn_pkg::box_type         cand,
   input  logic [8:0]               overlap_thr,
   output gwn_pkg::iou_status_type  status_out,
   output logic [TAG_W-1:0]         hit_tag
);
   import gwn_pkg::*;

   logic [23:0]        area_a_ff;

   logic signed [13:0] a_l, a_r, b_l, b_r, a_t, a_b, b_t, b_b;
   logic signed [13:0] x1, x2, y1, y2, dx_full, dy_full;
   logic               disj_in;

   logic               v2_ff, v3_ff, v4_ff, v5_ff;
   logic [11:0]        dx2_ff, dy2_ff;
   logic [23:0]        area_b2_ff;
   logic               disj2_ff, disj3_ff, disj4_ff, disj5_ff;
   logic [TAG_W-1:0]   tag2_ff, tag3_ff, tag4_ff, tag5_ff;
   logic [23:0]        inter3_ff, inter4_ff, inter5_ff;
   logic [24:0]        sum3_ff, union4_ff;
   logic [33:0]        prod5_ff, prod5_in;
   logic               match;

   // Candidate area stays fixed over a scan
   always_ff @(posedge clock) begin
      area_a_ff <= cand.w * cand.h;
   end

   // Intersection bounds of candidate and kept window
   always_comb begin
      a_l = $signed({cand.x[12], cand.x});
      a_t = $signed({cand.y[12], cand.y});
      b_l = $signed({in_box.x[12], in_box.x});
      b_t = $signed({in_box.y[12], in_box.y});
      a_r = a_l + $signed({2'b00, cand.w});
      a_b = a_t + $signed({2'b00, cand.h});
      b_r = b_l + $signed({2'b00, in_box.w});
      b_b = b_t + $signed({2'b00, in_box.h});
      x1 = (a_l > b_l) ? a_l : b_l;
      y1 = (a_t > b_t) ? a_t : b_t;
      x2 = (a_r < b_r) ? a_r : b_r;
      y2 = (a_b < b_b) ? a_b : b_b;
      dx_full = x2 - x1;
      dy_full = y2 - y1;
      disj_in = (x1 >= x2) || (y1 >= y2);
   end

   assign prod5_in = overlap_thr * union4_ff;

   // Advance valid flags, drop everything on flush
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v2_ff <= in_valid && !flush;
         v3_ff <= v2_ff && !flush;
         v4_ff <= v3_ff && !flush;
         v5_ff <= v4_ff && !flush;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      dx2_ff     <= dx_full[11:0];
      dy2_ff     <= dy_full[11:0];
      area_b2_ff <= in_box.w * in_box.h;
      disj2_ff   <= disj_in;
      tag2_ff    <= in_tag;

      inter3_ff  <= dx2_ff * dy2_ff;
      sum3_ff    <= 25'(area_a_ff) + 25'(area_b2_ff);
      disj3_ff   <= disj2_ff;
      tag3_ff    <= tag2_ff;

      union4_ff  <= sum3_ff - 25'(inter3_ff);
      inter4_ff  <= inter3_ff;
      disj4_ff   <= disj3_ff;
      tag4_ff    <= tag3_ff;

      prod5_ff   <= prod5_in;
      inter5_ff  <= inter4_ff;
      disj5_ff   <= disj4_ff;
      tag5_ff    <= tag4_ff;
   end

   // Disjoint windows count as zero overlap
   assign match = disj5_ff ? (overlap_thr == 9'd0)
                           : ({2'b00, inter5_ff, 8'h00} >= prod5_ff);

   assign status_out.hit  = v5_ff && match;
   assign status_out.busy = v2_ff || v3_ff || v4_ff || v5_ff;
   assign hit_tag         = tag5_ff;

   `GWN_ASSERT_NEXT(a_flush_empties, clock, reset, flush, !status_out.busy)
   `GWN_ASSERT_IMPLY(a_stage_order, clock, reset, v5_ff, $past(v4_ff))
   `GWN_ASSERT_IMPLY(a_stage_order_mid, clock, reset, v4_ff, $past(v3_ff))

endmodule

// ===== design/greedy_window_nms_unit.sv =====
// Greedy window suppression by overlap. Each req transfer carries a kind on
// req_tuser: offer a candidate window, read a kept entry, or clear the kept
// list. Offered windows must arrive in ascending cost order. A window whose
// cost is above the cost threshold is rejected; otherwise the kept list is
// scanned from entry 0 and the first kept window whose intersection-over-union
// reaches overlap_threshold/256 takes a hit (saturating) and the candidate is
// suppressed; with no match the candidate is appended, or reported as list
// full. Every request but the unused kind 3 yields exactly one rsp transfer.
// An offer streams the kept entries out of the entry memory one per cycle
// into a four-stage overlap pipeline, and the scan ends early when an entry
// matches. A new request is taken while the previous result still waits on
// rsp.
`include "greedy_window_nms_unit_macros.svh"

module greedy_window_nms_unit #(
   parameter int MAX_KEPT = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Requests
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // win_x, win_y, win_width, win_height, win_cost, read_index
   input  gwn_pkg::req_data_type                req_tdata,
   // req_type
   input  logic [1:0]                           req_tuser,
   // Results
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // entry_index, hit_count, out_x, out_y, out_width, out_height, out_cost,
   // kept_total, one zero pad bit
   output gwn_pkg::rsp_data_type                rsp_tdata,
   // status
   output gwn_pkg::status_type                  rsp_tuser,
   // Control register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gwn_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gwn_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import gwn_pkg::*;

   localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CNT_W = $clog2(MAX_KEPT + 1);
   localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
   localparam int TAG_W = 16 + IDX_W;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_RDWAIT = 4'b0100,
      S_RESULT = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic [15:0]        cost_thr_ff;
   logic [8:0]         overlap_thr_ff;
   req_data_type       cand_ff;
   box_type            cand_box;

   // Entry memories
   entry_type          box_mem [MAX_KEPT];
   logic [15:0]        hits_mem [MAX_KEPT];
   entry_type          box_rd_ff;
   logic [15:0]        hits_rd_ff;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               box_we;
   logic [IDX_W-1:0]   box_waddr;
   entry_type          box_wdata;
   logic               hits_we;
   logic [IDX_W-1:0]   hits_waddr;
   logic [15:0]        hits_wdata;

   logic               v1_ff, v1_in;
   logic [IDX_W-1:0]   idx1_ff;

   iou_status_type     iou_st;
   logic [TAG_W-1:0]   hit_tag;
   logic [IDX_W-1:0]   hit_idx;
   logic [15:0]        hit_hits;
   logic [15:0]        hits_new;

   logic               req_xfer;
   logic [CMP_W-1:0]   idx_ext;
   logic               idx_ok;

   status_type         res_status_ff, res_status_in;
   rsp_data_type       res_data_ff, res_data_in;
   logic               rsp_load;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   rsp_data_type       rsp_data_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign idx_ext = CMP_W'(req_tdata.read_index);
   assign idx_ok  = idx_ext < CMP_W'(count_ff);

   assign cand_box.x = cand_ff.win_x;
   assign cand_box.y = cand_ff.win_y;
   assign cand_box.w = cand_ff.win_width;
   assign cand_box.h = cand_ff.win_height;

   assign hit_idx  = hit_tag[IDX_W-1:0];
   assign hit_hits = hit_tag[TAG_W-1:IDX_W];
   assign hits_new = (hit_hits == HIT_MAX) ? hit_hits : hit_hits + 16'd1;

   // Sequencer: decode requests, scan the list, settle the outcome
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      v1_in         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = issue_ff[IDX_W-1:0];
      box_we        = 1'b0;
      box_waddr     = count_ff[IDX_W-1:0];
      box_wdata.box = cand_box;
      box_wdata.cost = cand_ff.win_cost;
      hits_we       = 1'b0;
      hits_waddr    = hit_idx;
      hits_wdata    = hits_new;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               res_data_in            = '0;
               res_data_in.kept_total = 7'(count_ff);
               case (req_tuser)
                  REQ_OFFER: begin
                     if (req_tdata.win_cost > cost_thr_ff) begin
                        res_status_in = ST_COST_REJ;
                        state_in      = S_RESULT;
                     end else begin
                        issue_in = '0;
                        state_in = S_SCAN;
                     end
                  end
                  REQ_READ: begin
                     if (idx_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_ext[IDX_W-1:0];
                        state_in = S_RDWAIT;
                     end else begin
                        res_status_in = ST_BAD_INDEX;
                        state_in      = S_RESULT;
                     end
                  end
                  REQ_CLEAR: begin
                     count_in               = '0;
                     res_status_in          = ST_CLEARED;
                     res_data_in.kept_total = 7'd0;
                     state_in               = S_RESULT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (iou_st.hit) begin
               // First match wins: write back its hit count, stop the scan
               hits_we                 = 1'b1;
               res_status_in           = ST_SUPPRESSED;
               res_data_in.entry_index = 6'(hit_idx);
               res_data_in.hit_count   = hits_new;
               state_in                = S_RESULT;
            end else if (issue_ff != count_ff) begin
               rd_en    = 1'b1;
               v1_in    = 1'b1;
               issue_in = issue_ff + 1'b1;
            end else if (!v1_ff && !iou_st.busy) begin
               if (count_ff >= CNT_W'(MAX_KEPT)) begin
                  res_status_in = ST_LIST_FULL;
               end else begin
                  // Append the candidate with a fresh hit count
                  box_we                  = 1'b1;
                  hits_we                 = 1'b1;
                  hits_waddr              = count_ff[IDX_W-1:0];
                  hits_wdata              = '0;
                  count_in                = count_ff + 1'b1;
                  res_status_in           = ST_KEPT;
                  res_data_in.entry_index = 6'(count_ff);
                  res_data_in.kept_total  = 7'(count_ff + 1'b1);
               end
               state_in = S_RESULT;
            end
         end
         S_RDWAIT: begin
            res_status_in           = ST_READ_OK;
            res_data_in.entry_index = cand_ff.read_index;
            res_data_in.hit_count   = hits_rd_ff;
            res_data_in.out_x       = box_rd_ff.box.x;
            res_data_in.out_y       = box_rd_ff.box.y;
            res_data_in.out_width   = box_rd_ff.box.w;
            res_data_in.out_height  = box_rd_ff.box.h;
            res_data_in.out_cost    = box_rd_ff.cost;
            state_in                = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hand the result to the output register once it is free
   assign rsp_load     = (state_ff == S_RESULT) && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         issue_ff       <= '0;
         v1_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         cost_thr_ff    <= COST_THR_RESET;
         overlap_thr_ff <= OVERLAP_THR_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         v1_ff        <= v1_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_COST_THR:    cost_thr_ff    <= csr_wdata;
               CSR_OVERLAP_THR: overlap_thr_ff <= csr_wdata[8:0];
               default:         ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cand_ff <= req_tdata;
      end
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_data_ff   <= res_data_ff;
      end
   end

   // Entry memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (box_we) begin
         box_mem[box_waddr] <= box_wdata;
      end
      if (hits_we) begin
         hits_mem[hits_waddr] <= hits_wdata;
      end
      if (rd_en) begin
         box_rd_ff  <= box_mem[rd_addr];
         hits_rd_ff <= hits_mem[rd_addr];
         idx1_ff    <= rd_addr;
      end
   end

   gwn_iou_pipe #(
      .TAG_W (TAG_W)
   ) u_iou_pipe (
      .clock       (clock),
      .reset       (reset),
      .flush       (iou_st.hit),
      .in_valid    (v1_ff),
      .in_box      (box_rd_ff.box),
      .in_tag      ({hits_rd_ff, idx1_ff}),
      .cand        (cand_box),
      .overlap_thr (overlap_thr_ff),
      .status_out  (iou_st),
      .hit_tag     (hit_tag)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   `GWN_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_KEPT))
   `GWN_ASSERT_IMPLY(a_hit_in_scan, clock, reset, iou_st.hit, state_ff == S_SCAN)
   `GWN_ASSERT_IMPLY(a_hit_below_count, clock, reset, iou_st.hit, CNT_W'(hit_idx) < count_ff)
   `GWN_ASSERT_IMPLY(a_append_drained, clock, reset, box_we, !v1_ff && !iou_st.busy)

endmodule

// ===== tb/sv/greedy_window_nms_unit_test.sv =====
module greedy_window_nms_unit_test;
   import gwn_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int LIST_DEPTH = 64;
   localparam int DRAIN_CYCLES = 100;
   localparam int RANDOM_ITEMS = 1950;
   localparam int NUM_DIRECTED = 23;

   // One result as seen on rsp, status first
   typedef struct packed {
      status_type  status;
      logic [5:0]  index;
      logic [15:0] hits;
      logic [12:0] x;
      logic [12:0] y;
      logic [11:0] w;
      logic [11:0] h;
      logic [15:0] cost;
      logic [6:0]  total;
   } nms_result_type;

   // Register settings applied before a directed row
   typedef struct packed {
      bit          on;
      logic [15:0] cost;
      logic [8:0]  overlap;
   } csr_plan_type;

   // One directed request, with a hand-written result where typed is set
   typedef struct packed {
      logic [1:0]         kind;
      logic signed [12:0] x;
      logic signed [12:0] y;
      logic [11:0]        w;
      logic [11:0]        h;
      logic [15:0]        cost;
      logic [5:0]         idx;
      csr_plan_type       csr;
      bit                 typed;
      nms_result_type     want;
   } directed_row_type;

   localparam csr_plan_type NO_CSR = '0;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   req_data_type req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   rsp_data_type rsp_tdata;
   status_type   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow of the kept list and the registers
   int          kept_x [LIST_DEPTH];
   int          kept_y [LIST_DEPTH];
   int          kept_w [LIST_DEPTH];
   int          kept_h [LIST_DEPTH];
   logic [15:0] kept_cost [LIST_DEPTH];
   logic [15:0] kept_hits [LIST_DEPTH];
   int          kept_len;
   logic [15:0] cost_limit;
   logic [8:0]  overlap_limit;

   nms_result_type   pending_results [$];
   nms_result_type   head;
   directed_row_type plan [NUM_DIRECTED];
   int               mismatches = 0;
   int               requests_sent = 0;
   int               send_idle_pct = 0;
   int               rsp_stall_pct = 0;

   greedy_window_nms_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #80_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Overlap test of a candidate against kept entry j, exact in 64 bits
   function automatic bit windows_overlap(input int ax, input int ay, input int aw,
                                          input int ah, input int j);
      int     x1;
      int     y1;
      int     x2;
      int     y2;
      longint inter;
      longint area_union;
      x1 = (ax > kept_x[j]) ? ax : kept_x[j];
      y1 = (ay > kept_y[j]) ? ay : kept_y[j];
      x2 = (ax + aw < kept_x[j] + kept_w[j]) ? ax + aw : kept_x[j] + kept_w[j];
      y2 = (ay + ah < kept_y[j] + kept_h[j]) ? ay + ah : kept_y[j] + kept_h[j];
      // disjoint or empty windows count as zero overlap
      if (x1 >= x2 || y1 >= y2) return overlap_limit == 9'd0;
      inter = longint'(x2 - x1) * longint'(y2 - y1);
      area_union = longint'(aw) * longint'(ah) +
                   longint'(kept_w[j]) * longint'(kept_h[j]) - inter;
      return inter * 256 >= longint'(overlap_limit) * area_union;
   endfunction

   // Advance the shadow list by one request; return 1 when a result follows
   function automatic bit forecast_result(input logic [1:0] kind, input req_data_type d,
                                          output nms_result_type r);
      int ax;
      int ay;
      int aw;
      int ah;
      int j;
      int slot;
      bit found;
      r = '0;
      found = 1'b0;
      slot = 0;
      ax = {{19{d.win_x[12]}}, d.win_x};
      ay = {{19{d.win_y[12]}}, d.win_y};
      aw = int'(d.win_width);
      ah = int'(d.win_height);
      case (kind)
         REQ_OFFER: begin
            if (d.win_cost > cost_limit) begin
               r.status = ST_COST_REJ;
            end else begin
               // first matching entry wins
               for (j = 0; j < kept_len && !found; j++) begin
                  if (windows_overlap(ax, ay, aw, ah, j)) begin
                     found = 1'b1;
                     slot = j;
                  end
               end
               if (found) begin
                  if (kept_hits[slot] != HIT_MAX) kept_hits[slot] = kept_hits[slot] + 16'd1;
                  r.status = ST_SUPPRESSED;
                  r.index = 6'(slot);
                  r.hits = kept_hits[slot];
               end else if (kept_len >= LIST_DEPTH) begin
                  r.status = ST_LIST_FULL;
               end else begin
                  kept_x[kept_len] = ax;
                  kept_y[kept_len] = ay;
                  kept_w[kept_len] = aw;
                  kept_h[kept_len] = ah;
                  kept_cost[kept_len] = d.win_cost;
                  kept_hits[kept_len] = 16'd0;
                  r.status = ST_KEPT;
                  r.index = 6'(kept_len);
                  kept_len++;
               end
            end
         end
         REQ_READ: begin
            if (int'(d.read_index) < kept_len) begin
               slot = int'(d.read_index);
               r.status = ST_READ_OK;
               r.index = d.read_index;
               r.hits = kept_hits[slot];
               r.x = 13'(kept_x[slot]);
               r.y = 13'(kept_y[slot]);
               r.w = 12'(kept_w[slot]);
               r.h = 12'(kept_h[slot]);
               r.cost = kept_cost[slot];
            end else begin
               r.status = ST_BAD_INDEX;
            end
         end
         REQ_CLEAR: begin
            kept_len = 0;
            r.status = ST_CLEARED;
         end
         default: return 1'b0;
      endcase
      r.total = 7'(kept_len);
      return 1'b1;
   endfunction

   function automatic nms_result_type status_only(input status_type st, input int total);
      nms_result_type r;
      r = '0;
      r.status = st;
      r.total = 7'(total);
      return r;
   endfunction

   function automatic nms_result_type entry_only(input status_type st, input int idx,
                                                 input int hits, input int total);
      nms_result_type r;
      r = status_only(st, total);
      r.index = 6'(idx);
      r.hits = 16'(hits);
      return r;
   endfunction

   function automatic nms_result_type read_back(input int idx, input int hits, input int x,
                                                input int y, input int w, input int h,
                                                input int cost, input int total);
      nms_result_type r;
      r = entry_only(ST_READ_OK, idx, hits, total);
      r.x = 13'(x);
      r.y = 13'(y);
      r.w = 12'(w);
      r.h = 12'(h);
      r.cost = 16'(cost);
      return r;
   endfunction

   function automatic req_data_type random_payload();
      logic [95:0] raw;
      raw = {$urandom(), $urandom(), $urandom()};
      return raw[71:0];
   endfunction

   function automatic void set_idle_phase(input int phase);
      case (phase)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 88; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 88; end
         default: begin send_idle_pct = 17; rsp_stall_pct = 17; end
      endcase
   endfunction

   // Offer one request; called and returning at a falling edge
   task automatic send_request(input logic [1:0] kind, input req_data_type d,
                               input bit typed, input nms_result_type want);
      nms_result_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      // transfer taken: update the shadow state and queue the result
      if (forecast_result(kind, d, predicted)) begin
         pending_results = {pending_results, (typed ? want : predicted)};
         requests_sent++;
      end
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_COST_THR:    cost_limit = data;
         CSR_OVERLAP_THR: overlap_limit = data[8:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Drop valid, wait for every result, then let the block go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic check_field(input string label, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      end
   endtask

   // Receiver backpressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual status %0d",
                     $time, rsp_tuser);
         end else begin
            head = pending_results.pop_front();
            check_field("status", 16'(head.status), 16'(rsp_tuser));
            check_field("entry_index", 16'(head.index), 16'(rsp_tdata.entry_index));
            check_field("hit_count", head.hits, rsp_tdata.hit_count);
            check_field("out_x", {3'b0, head.x}, {3'b0, rsp_tdata.out_x});
            check_field("out_y", {3'b0, head.y}, {3'b0, rsp_tdata.out_y});
            check_field("out_width", 16'(head.w), 16'(rsp_tdata.out_width));
            check_field("out_height", 16'(head.h), 16'(rsp_tdata.out_height));
            check_field("out_cost", head.cost, rsp_tdata.out_cost);
            check_field("kept_total", 16'(head.total), 16'(rsp_tdata.kept_total));
         end
      end
   end

   initial begin
      req_data_type d;
      int           ep;
      int           n;
      int           pick;
      int           c;
      int           grid_pos;
      int           running_cost;
      int           cx [3];
      int           cy [3];
      int           cw [3];
      int           ch [3];
      bit           fill;
      logic [15:0]  cthr;
      logic [8:0]   othr;

      kept_len = 0;
      cost_limit = COST_THR_RESET;
      overlap_limit = OVERLAP_THR_RESET;

      plan = '{
         // empty list: read fails, clear is harmless, unused kind is dropped
         '{REQ_READ, 13'sd0, 13'sd0, 12'd0, 12'd0, 16'd0, 6'd0, NO_CSR, 1'b1,
           status_only(ST_BAD_INDEX, 0)},
         '{REQ_CLEAR, 13'sd0, 13'sd0, 12'd0, 12'd0, 16'd0, 6'd0, NO_CSR, 1'b1,
           status_only(ST_CLEARED, 0)},
         '{REQ_UNUSED, 13'h1FFF, 13'h1FFF, 12'hFFF, 12'hFFF, 16'hFFFF, 6'h3F, NO_CSR,
           1'b0, '0},
         // largest window at the lowest corner, then its twin
         '{REQ_OFFER, 13'h1000, 13'h1000, 12'hFFF, 12'hFFF, 16'd0, 6'd0, NO_CSR, 1'b1,
           entry_only(ST_KEPT, 0, 0, 1)},
         '{REQ_OFFER, 13'h1000, 13'h1000, 12'hFFF, 12'hFFF, 16'd1, 6'd0, NO_CSR, 1'b1,
           entry_only(ST_SUPPRESSED, 0, 1, 1)},
         // empty window at the highest corner never overlaps
         '{REQ_OFFER, 13'sd4095, 13'sd4095, 12'd0, 12'd0, 16'd2, 6'd0, NO_CSR, 1'b1,
           entry_only(ST_KEPT, 1, 0, 2)},
         '{REQ_READ, 13'sd0, 13'sd0, 12'd0, 12'd0, 16'd0, 6'd1, NO_CSR, 1'b1,
           read_back(1, 0, 4095, 4095, 0, 0, 2, 2)},
         '{REQ_READ, 13'sd0, 13'sd0, 12'd0, 12'd0, 16'd0, 6'd0, NO_CSR, 1'b1,
           read_back(0, 1, -4096, -4096, 4095, 4095, 0, 2)},
         '{REQ_READ, 13'sd0, 13'sd0, 12'd0, 12'd0, 16'd0, 6'd63, NO_CSR, 1'b1,
           status_only(ST_BAD_INDEX, 2)},
         // cost equal to the threshold is accepted
         '{REQ_OFFER, 13'sd100, 13'sd100, 12'd10, 12'd10, 16'hFFFF, 6'd0, NO_CSR, 1'b1,
           entry_only(ST_KEPT, 2, 0, 3)},
         '{REQ_OFFER, 13'sd105, 13'sd100, 12'd10, 12'd10, 16'hFFFF, 6'd0, NO_CSR, 1'b0,
           '0},
         '{REQ_OFFER, 13'sd102, 13'sd100, 12'd10, 12'd10, 16'hFFFF, 6'd0, NO_CSR, 1'b0,
           '0},
         '{REQ_READ, 13'sd0, 13'sd0, 12'd0, 12'd0, 16'd0, 6'd42, NO_CSR, 1'b1,
           status_only(ST_BAD_INDEX, 4)},
         // zero overlap threshold: disjoint windows match
         '{REQ_OFFER, 13'sd0, 13'sd0, 12'd1, 12'd1, 16'd1001, 6'd0,
           '{1'b1, 16'd1000, 9'd0}, 1'b1, status_only(ST_COST_REJ, 4)},
         '{REQ_OFFER, 13'sd0, 13'sd0, 12'd1, 12'd1, 16'd1000, 6'd0, NO_CSR, 1'b0, '0},
         // full overlap threshold, zero cost threshold
         '{REQ_OFFER, 13'sd100, 13'sd100, 12'd10, 12'd10, 16'd0, 6'd0,
           '{1'b1, 16'd0, 9'd256}, 1'b0, '0},
         '{REQ_OFFER, 13'sd100, 13'sd100, 12'd10, 12'd10, 16'd1, 6'd0, NO_CSR, 1'b1,
           status_only(ST_COST_REJ, 4)},
         // threshold above one: nothing can match
         '{REQ_OFFER, 13'sd100, 13'sd100, 12'd10, 12'd10, 16'd5, 6'd0,
           '{1'b1, 16'hFFFF, 9'd511}, 1'b0, '0},
         '{REQ_OFFER, 13'sd4095, 13'h1000, 12'hFFF, 12'd1, 16'd7, 6'd0, NO_CSR, 1'b0,
           '0},
         '{REQ_READ, 13'sd0, 13'sd0, 12'd0, 12'd0, 16'd0, 6'd4, NO_CSR, 1'b0, '0},
         '{REQ_CLEAR, 13'sd0, 13'sd0, 12'd0, 12'd0, 16'd0, 6'd0, NO_CSR, 1'b1,
           status_only(ST_CLEARED, 0)},
         '{REQ_READ, 13'sd0, 13'sd0, 12'd0, 12'd0, 16'd0, 6'd0, NO_CSR, 1'b1,
           status_only(ST_BAD_INDEX, 0)},
         '{REQ_UNUSED, 13'sd0, 13'sd0, 12'd0, 12'd0, 16'd0, 6'd0, NO_CSR, 1'b0, '0}
      };

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table
      set_idle_phase(0);
      for (ep = 0; ep < NUM_DIRECTED; ep++) begin
         if (plan[ep].csr.on) begin
            settle();
            write_csr(CSR_COST_THR, plan[ep].csr.cost);
            write_csr(CSR_OVERLAP_THR, {7'd0, plan[ep].csr.overlap});
         end
         d = '0;
         d.win_x = plan[ep].x;
         d.win_y = plan[ep].y;
         d.win_width = plan[ep].w;
         d.win_height = plan[ep].h;
         d.win_cost = plan[ep].cost;
         d.read_index = plan[ep].idx;
         send_request(plan[ep].kind, d, plan[ep].typed, plan[ep].want);
      end

      // Random episodes, each with its own register setting and idle phase
      requests_sent = 0;
      ep = 0;
      while (requests_sent < RANDOM_ITEMS) begin
         settle();
         set_idle_phase(ep % 4);
         fill = (ep % 5 == 4);
         pick = $urandom_range(0, 9);
         if (fill || pick > 3) cthr = 16'hFFFF;
         else if (pick == 0) cthr = 16'd0;
         else cthr = 16'($urandom_range(0, 65535));
         pick = $urandom_range(0, 9);
         if (fill || pick > 2) othr = 9'($urandom_range(1, 256));
         else if (pick == 0) othr = 9'd0;
         else if (pick == 1) othr = 9'd256;
         else othr = 9'($urandom_range(257, 511));
         write_csr(CSR_COST_THR, cthr);
         write_csr(CSR_OVERLAP_THR, {7'd0, othr});
         if (fill || $urandom_range(0, 3) != 0)
            send_request(REQ_CLEAR, random_payload(), 1'b0, '0);

         if (fill) begin
            // one window per grid square fills the list; the last row overflows it
            for (grid_pos = 0; grid_pos < LIST_DEPTH + 8; grid_pos++) begin
               d = random_payload();
               d.win_x = 13'(-4096 + (grid_pos % 8) * 1024 + int'($urandom_range(0, 100)));
               d.win_y = 13'(-4096 + ((grid_pos / 8) % 8) * 1024 +
                             int'($urandom_range(0, 100)));
               d.win_width = 12'($urandom_range(1, 900));
               d.win_height = 12'($urandom_range(1, 900));
               d.win_cost = 16'(grid_pos * 50);
               send_request(REQ_OFFER, d, 1'b0, '0);
            end
            repeat (8) send_request(REQ_READ, random_payload(), 1'b0, '0);
         end else begin
            // candidates jitter around a few centers so that many overlap
            for (c = 0; c < 3; c++) begin
               cx[c] = int'($urandom_range(0, 7800)) - 4000;
               cy[c] = int'($urandom_range(0, 7800)) - 4000;
               cw[c] = int'($urandom_range(1, 150));
               ch[c] = int'($urandom_range(1, 150));
            end
            running_cost = int'($urandom_range(0, 2000));
            n = int'($urandom_range(10, 50));
            repeat (n) begin
               d = random_payload();
               pick = int'($urandom_range(0, 99));
               if (pick < 70) begin
                  c = int'($urandom_range(0, 2));
                  if (pick >= 7) begin
                     d.win_x = 13'(cx[c] + int'($urandom_range(0, 40)) - 20);
                     d.win_y = 13'(cy[c] + int'($urandom_range(0, 40)) - 20);
                     d.win_width = 12'(cw[c] + int'($urandom_range(0, 20)));
                     d.win_height = 12'(ch[c] + int'($urandom_range(0, 20)));
                  end
                  running_cost += int'($urandom_range(0, 800));
                  d.win_cost = (running_cost > 65535) ? 16'hFFFF : 16'(running_cost);
                  send_request(REQ_OFFER, d, 1'b0, '0);
               end else if (pick < 85) begin
                  if (kept_len > 0 && $urandom_range(0, 4) != 0)
                     d.read_index = 6'($urandom_range(0, kept_len - 1));
                  send_request(REQ_READ, d, 1'b0, '0);
               end else if (pick < 88) begin
                  send_request(REQ_CLEAR, d, 1'b0, '0);
               end else if (pick < 91) begin
                  send_request(REQ_UNUSED, d, 1'b0, '0);
               end else begin
                  // out-of-order cost and arbitrary geometry
                  send_request(REQ_OFFER, d, 1'b0, '0);
               end
            end
         end
         ep++;
      end

      settle();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
